// File: rtl/e2q_pkg.sv
// Shared widths, constants and the arctangent table for the Euler to quaternion pipeline.
package e2q_pkg;

    localparam int ANGLE_WIDTH = 16;
    localparam int QUAT_WIDTH  = 16;
    localparam int TRIG_STAGES = 16;

    // CORDIC datapath width (Q2.30 plus headroom)
    localparam int CW  = 34;
    // multiplier operand width
    localparam int MW  = 32;
    // full product width (Q60)
    localparam int PW  = 64;
    // width of a sum of two Q60 terms
    localparam int SW  = 65;
    // output shift from Q60 down to QUAT_WIDTH-2 fraction bits
    localparam int SH  = 62 - QUAT_WIDTH;
    // pre-rotation, CORDIC stages, two multiply stages, one sum stage
    localparam int LAT = TRIG_STAGES + 4;

    localparam logic signed [CW-1:0] HALF_PI_Q30     = CW'(64'sd1686629713);
    localparam logic signed [CW-1:0] CORDIC_GAIN_Q30 = CW'(64'sd652032874);

    typedef logic signed [CW-1:0] cval_t;
    typedef logic signed [MW-1:0] mval_t;
    typedef logic signed [PW-1:0] prod_t;
    typedef logic signed [SW-1:0] sum_t;

    localparam cval_t ATAN_Q30 [32] = '{
        CW'(843314857), CW'(497837829), CW'(263043837), CW'(133525159),
        CW'(67021687),  CW'(33543516),  CW'(16775851),  CW'(8388437),
        CW'(4194283),   CW'(2097149),   CW'(1048576),   CW'(524288),
        CW'(262144),    CW'(131072),    CW'(65536),     CW'(32768),
        CW'(16384),     CW'(8192),      CW'(4096),      CW'(2048),
        CW'(1024),      CW'(512),       CW'(256),       CW'(128),
        CW'(64),        CW'(32),        CW'(16),        CW'(8),
        CW'(4),         CW'(2),         CW'(1),         CW'(0)
    };

endpackage

// File: rtl/e2q_cordic.sv
// Pipelined rotation-mode CORDIC giving sine and cosine of half of one angle.
module e2q_cordic (
    input  logic                              clk,
    input  logic                              en,
    input  logic [e2q_pkg::ANGLE_WIDTH-1:0]   angle,
    output e2q_pkg::cval_t                    cos_val,
    output e2q_pkg::cval_t                    sin_val
);

    e2q_pkg::cval_t x_reg [e2q_pkg::TRIG_STAGES+1];
    e2q_pkg::cval_t y_reg [e2q_pkg::TRIG_STAGES+1];
    e2q_pkg::cval_t z_reg [e2q_pkg::TRIG_STAGES+1];

    e2q_pkg::cval_t half_ang;
    e2q_pkg::cval_t x_next, y_next, z_next;

    // Halve the angle into Q30 and pre-rotate by a quarter turn if needed
    always_comb
    begin
        half_ang = e2q_pkg::cval_t'({{(e2q_pkg::CW - e2q_pkg::ANGLE_WIDTH)
                    {angle[e2q_pkg::ANGLE_WIDTH-1]}}, angle}) <<< (32 - e2q_pkg::ANGLE_WIDTH);
        if (half_ang > e2q_pkg::HALF_PI_Q30)
        begin
            x_next = '0;
            y_next = e2q_pkg::CORDIC_GAIN_Q30;
            z_next = half_ang - e2q_pkg::HALF_PI_Q30;
        end
        else if (half_ang < -e2q_pkg::HALF_PI_Q30)
        begin
            x_next = '0;
            y_next = -e2q_pkg::CORDIC_GAIN_Q30;
            z_next = half_ang + e2q_pkg::HALF_PI_Q30;
        end
        else
        begin
            x_next = e2q_pkg::CORDIC_GAIN_Q30;
            y_next = '0;
            z_next = half_ang;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x_reg[0] <= x_next;
            y_reg[0] <= y_next;
            z_reg[0] <= z_next;
        end
    end

    // One micro-rotation per stage, direction from the sign of z
    for (genvar i = 0; i < e2q_pkg::TRIG_STAGES; i++)
    begin : g_stage
        e2q_pkg::cval_t xs, ys;
        assign xs = x_reg[i] >>> i;
        assign ys = y_reg[i] >>> i;

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                if (!z_reg[i][e2q_pkg::CW-1])
                begin
                    x_reg[i+1] <= x_reg[i] - ys;
                    y_reg[i+1] <= y_reg[i] + xs;
                    z_reg[i+1] <= z_reg[i] - e2q_pkg::ATAN_Q30[i];
                end
                else
                begin
                    x_reg[i+1] <= x_reg[i] + ys;
                    y_reg[i+1] <= y_reg[i] - xs;
                    z_reg[i+1] <= z_reg[i] + e2q_pkg::ATAN_Q30[i];
                end
            end
        end
    end

    assign cos_val = x_reg[e2q_pkg::TRIG_STAGES];
    assign sin_val = y_reg[e2q_pkg::TRIG_STAGES];

endmodule

// File: rtl/e2q_combine.sv
// Three-stage product, sum, rounding and saturation forming the quaternion.
module e2q_combine (
    input  logic                                   clk,
    input  logic                                   en,
    input  e2q_pkg::cval_t                         sr,
    input  e2q_pkg::cval_t                         cr,
    input  e2q_pkg::cval_t                         sp,
    input  e2q_pkg::cval_t                         cp,
    input  e2q_pkg::cval_t                         sy,
    input  e2q_pkg::cval_t                         cy,
    output logic signed [e2q_pkg::QUAT_WIDTH-1:0]  quat_x,
    output logic signed [e2q_pkg::QUAT_WIDTH-1:0]  quat_y,
    output logic signed [e2q_pkg::QUAT_WIDTH-1:0]  quat_z,
    output logic signed [e2q_pkg::QUAT_WIDTH-1:0]  quat_w
);

    localparam e2q_pkg::prod_t RND30 = e2q_pkg::prod_t'(64'sd1) <<< 29;
    localparam e2q_pkg::sum_t  RNDQ  = e2q_pkg::sum_t'(65'sd1) <<< (e2q_pkg::SH - 1);
    localparam e2q_pkg::sum_t  LIM   = e2q_pkg::sum_t'(65'sd1) <<< (e2q_pkg::QUAT_WIDTH - 2);

    // stage one: pair products rounded back to Q30
    e2q_pkg::mval_t srcp_reg, crsp_reg, crcp_reg, srsp_reg, sy_reg, cy_reg;
    e2q_pkg::prod_t srcp_p, crsp_p, crcp_p, srsp_p;
    e2q_pkg::prod_t srcp_r, crsp_r, crcp_r, srsp_r;

    // stage two: three-factor Q60 terms
    e2q_pkg::prod_t t_reg [8];

    // stage three: rounded and clamped outputs
    logic signed [e2q_pkg::QUAT_WIDTH-1:0] q_reg [4];
    logic signed [e2q_pkg::QUAT_WIDTH-1:0] q_next [4];
    e2q_pkg::sum_t s_val [4];
    e2q_pkg::sum_t r_val [4];

    always_comb
    begin
        srcp_p = e2q_pkg::mval_t'(sr) * e2q_pkg::mval_t'(cp);
        crsp_p = e2q_pkg::mval_t'(cr) * e2q_pkg::mval_t'(sp);
        crcp_p = e2q_pkg::mval_t'(cr) * e2q_pkg::mval_t'(cp);
        srsp_p = e2q_pkg::mval_t'(sr) * e2q_pkg::mval_t'(sp);
        srcp_r = (srcp_p + RND30) >>> 30;
        crsp_r = (crsp_p + RND30) >>> 30;
        crcp_r = (crcp_p + RND30) >>> 30;
        srsp_r = (srsp_p + RND30) >>> 30;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            srcp_reg <= srcp_r[e2q_pkg::MW-1:0];
            crsp_reg <= crsp_r[e2q_pkg::MW-1:0];
            crcp_reg <= crcp_r[e2q_pkg::MW-1:0];
            srsp_reg <= srsp_r[e2q_pkg::MW-1:0];
            sy_reg   <= e2q_pkg::mval_t'(sy);
            cy_reg   <= e2q_pkg::mval_t'(cy);
        end
    end

    // Multiply each pair by the yaw factor
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            t_reg[0] <= srcp_reg * cy_reg;
            t_reg[1] <= crsp_reg * sy_reg;
            t_reg[2] <= crsp_reg * cy_reg;
            t_reg[3] <= srcp_reg * sy_reg;
            t_reg[4] <= crcp_reg * sy_reg;
            t_reg[5] <= srsp_reg * cy_reg;
            t_reg[6] <= crcp_reg * cy_reg;
            t_reg[7] <= srsp_reg * sy_reg;
        end
    end

    // Add, round half up and clamp to plus and minus one
    always_comb
    begin
        s_val[0] = e2q_pkg::sum_t'(t_reg[0]) - e2q_pkg::sum_t'(t_reg[1]);
        s_val[1] = e2q_pkg::sum_t'(t_reg[2]) + e2q_pkg::sum_t'(t_reg[3]);
        s_val[2] = e2q_pkg::sum_t'(t_reg[4]) - e2q_pkg::sum_t'(t_reg[5]);
        s_val[3] = e2q_pkg::sum_t'(t_reg[6]) + e2q_pkg::sum_t'(t_reg[7]);
        for (int k = 0; k < 4; k++)
        begin
            r_val[k] = (s_val[k] + RNDQ) >>> e2q_pkg::SH;
            if (r_val[k] > LIM)
                r_val[k] = LIM;
            if (r_val[k] < -LIM)
                r_val[k] = -LIM;
            q_next[k] = r_val[k][e2q_pkg::QUAT_WIDTH-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < 4; k++)
                q_reg[k] <= q_next[k];
        end
    end

    assign quat_x = q_reg[0];
    assign quat_y = q_reg[1];
    assign quat_z = q_reg[2];
    assign quat_w = q_reg[3];

endmodule

// File: rtl/euler_to_quaternion.sv
// Top level: ZYX Euler angles to quaternion, fully pipelined.
//
// Takes roll, pitch and yaw (signed Q3.13 radians) and returns the quaternion
// x, y, z, w as signed Q1.14, saturated to plus and minus one. One word is
// accepted per cycle while the output word is taken or absent; each result
// passes one pre-rotation stage, one register per CORDIC micro-rotation, two
// multiply stages and one sum and rounding stage. The pipeline is a single
// chain of stages that all hold together when the output word is not taken,
// so the sustained rate is one word per cycle while out_ready is held high.
module euler_to_quaternion (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    in_valid,
    output logic                                    in_ready,
    input  logic signed [e2q_pkg::ANGLE_WIDTH-1:0]  roll,
    input  logic signed [e2q_pkg::ANGLE_WIDTH-1:0]  pitch,
    input  logic signed [e2q_pkg::ANGLE_WIDTH-1:0]  yaw,
    output logic                                    out_valid,
    input  logic                                    out_ready,
    output logic signed [e2q_pkg::QUAT_WIDTH-1:0]   quat_x,
    output logic signed [e2q_pkg::QUAT_WIDTH-1:0]   quat_y,
    output logic signed [e2q_pkg::QUAT_WIDTH-1:0]   quat_z,
    output logic signed [e2q_pkg::QUAT_WIDTH-1:0]   quat_w
);

    logic [e2q_pkg::LAT-1:0] valid_reg;
    logic [e2q_pkg::LAT-1:0] valid_next;
    logic                    advance;

    e2q_pkg::cval_t cr, sr, cp, sp, cy, sy;

    // Advance the whole chain unless the output word is stalled
    assign advance   = !valid_reg[e2q_pkg::LAT-1] || out_ready;
    assign in_ready  = advance;
    assign out_valid = valid_reg[e2q_pkg::LAT-1];

    assign valid_next = {valid_reg[e2q_pkg::LAT-2:0], in_valid};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else if (advance)
            valid_reg <= valid_next;
    end

    e2q_cordic u_roll (
        .clk     (clk),
        .en      (advance),
        .angle   (roll),
        .cos_val (cr),
        .sin_val (sr)
    );

    e2q_cordic u_pitch (
        .clk     (clk),
        .en      (advance),
        .angle   (pitch),
        .cos_val (cp),
        .sin_val (sp)
    );

    e2q_cordic u_yaw (
        .clk     (clk),
        .en      (advance),
        .angle   (yaw),
        .cos_val (cy),
        .sin_val (sy)
    );

    e2q_combine u_combine (
        .clk    (clk),
        .en     (advance),
        .sr     (sr),
        .cr     (cr),
        .sp     (sp),
        .cp     (cp),
        .sy     (sy),
        .cy     (cy),
        .quat_x (quat_x),
        .quat_y (quat_y),
        .quat_z (quat_z),
        .quat_w (quat_w)
    );

endmodule
